// ----- rtl/ripemd128_hash_engine_macros.svh -----
// Assertion helpers for the hash engine
`ifndef RIPEMD128_HASH_ENGINE_MACROS_SVH
`define RIPEMD128_HASH_ENGINE_MACROS_SVH
// Check an implication on every clock edge outside reset
`define RMD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check that an implication holds in the following cycle
`define RMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/rmd128_pkg.sv -----
`default_nettype none
package rmd128_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       wr_en;      // write a byte into the block store
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic       cnt_inc;    // advance the byte count
    logic       len_snap;   // capture the bit length
    logic       start;      // load working words from the chaining value
    logic       step;       // run one round of both lines
    logic [5:0] round;
    logic       combine;    // fold lines into the chaining value
    logic       init;       // restore the initial chaining value
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [5:0] pos;        // byte count modulo block size
  } dp_status_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [5:0]  LEN_POS = 6'd56;

  function automatic logic [3:0] sel_l(input logic [5:0] i);
    logic [255:0] t;
    t = {4'd2,4'd6,4'd5,4'd14,4'd15,4'd7,4'd3,4'd13,4'd4,4'd12,4'd8,4'd0,4'd10,4'd11,4'd9,4'd1,
         4'd12,4'd5,4'd11,4'd13,4'd6,4'd0,4'd7,4'd2,4'd1,4'd8,4'd15,4'd9,4'd4,4'd14,4'd10,4'd3,
         4'd8,4'd11,4'd14,4'd2,4'd5,4'd9,4'd0,4'd12,4'd3,4'd15,4'd6,4'd10,4'd1,4'd13,4'd4,4'd7,
         4'd15,4'd14,4'd13,4'd12,4'd11,4'd10,4'd9,4'd8,4'd7,4'd6,4'd5,4'd4,4'd3,4'd2,4'd1,4'd0};
    return t[{i, 2'b00} +: 4];
  endfunction

  function automatic logic [3:0] sel_r(input logic [5:0] i);
    logic [255:0] t;
    t = {4'd14,4'd10,4'd7,4'd9,4'd13,4'd2,4'd12,4'd5,4'd0,4'd15,4'd11,4'd3,4'd1,4'd4,4'd6,4'd8,
         4'd13,4'd4,4'd0,4'd10,4'd2,4'd12,4'd8,4'd11,4'd9,4'd6,4'd14,4'd7,4'd3,4'd1,4'd5,4'd15,
         4'd2,4'd1,4'd9,4'd4,4'd12,4'd8,4'd15,4'd14,4'd10,4'd5,4'd13,4'd0,4'd7,4'd3,4'd11,4'd6,
         4'd12,4'd3,4'd10,4'd1,4'd8,4'd15,4'd6,4'd13,4'd4,4'd11,4'd2,4'd9,4'd0,4'd7,4'd14,4'd5};
    return t[{i, 2'b00} +: 4];
  endfunction

  function automatic logic [3:0] rot_l(input logic [5:0] i);
    logic [255:0] t;
    t = {4'd12,4'd5,4'd6,4'd8,4'd6,4'd5,4'd14,4'd9,4'd8,4'd9,4'd15,4'd14,4'd15,4'd14,4'd12,4'd11,
         4'd5,4'd7,4'd12,4'd5,4'd6,4'd13,4'd8,4'd14,4'd15,4'd13,4'd9,4'd14,4'd7,4'd6,4'd13,4'd11,
         4'd12,4'd13,4'd7,4'd11,4'd9,4'd15,4'd12,4'd7,4'd15,4'd7,4'd9,4'd11,4'd13,4'd8,4'd6,4'd7,
         4'd8,4'd9,4'd7,4'd6,4'd15,4'd14,4'd13,4'd11,4'd9,4'd7,4'd8,4'd5,4'd12,4'd15,4'd14,4'd11};
    return t[{i, 2'b00} +: 4];
  endfunction

  function automatic logic [3:0] rot_r(input logic [5:0] i);
    logic [255:0] t;
    t = {4'd8,4'd15,4'd5,4'd12,4'd9,4'd12,4'd9,4'd6,4'd14,4'd6,4'd14,4'd14,4'd11,4'd8,4'd5,4'd15,
         4'd5,4'd7,4'd13,4'd13,4'd14,4'd5,4'd13,4'd12,4'd14,4'd6,4'd6,4'd8,4'd11,4'd15,4'd7,4'd9,
         4'd11,4'd13,4'd15,4'd6,4'd7,4'd12,4'd7,4'd7,4'd11,4'd9,4'd8,4'd12,4'd7,4'd15,4'd13,4'd9,
         4'd6,4'd12,4'd14,4'd14,4'd11,4'd8,4'd7,4'd7,4'd5,4'd15,4'd15,4'd13,4'd11,4'd9,4'd9,4'd8};
    return t[{i, 2'b00} +: 4];
  endfunction

  function automatic logic [31:0] bfun(input logic [1:0] g, input logic [31:0] x,
                                       input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    case (g)
      2'd0:    r = x ^ y ^ z;
      2'd1:    r = (x & y) | (~x & z);
      2'd2:    r = (x | ~y) ^ z;
      default: r = (x & z) | (y & ~z);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] add_l(input logic [1:0] g);
    logic [31:0] r;
    case (g)
      2'd0:    r = 32'h00000000;
      2'd1:    r = 32'h5a827999;
      2'd2:    r = 32'h6ed9eba1;
      default: r = 32'h8f1bbcdc;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] add_r(input logic [1:0] g);
    logic [31:0] r;
    case (g)
      2'd0:    r = 32'h50a28be6;
      2'd1:    r = 32'h5c4dd124;
      2'd2:    r = 32'h6d703ef3;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [3:0] s);
    logic [63:0] d;
    d = {v, v} << s;
    return d[63:32];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rmd128_datapath.sv -----
`default_nettype none
module rmd128_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rmd128_pkg::dp_cmd_t  cmd,
  output rmd128_pkg::dp_status_t    status,
  output logic [127:0]              chain,
  output logic [63:0]               len_bits
);
  import rmd128_pkg::*;

  logic [31:0] store [16];
  logic [63:0] byte_count;
  logic [63:0] bits;
  logic [31:0] cv [4];
  logic [31:0] al, bl, cl, dl, ar, br, cr, dr;
  logic [31:0] tl, tr;
  logic [1:0]  g;

  assign status.pos = byte_count[5:0];
  assign chain = {cv[3], cv[2], cv[1], cv[0]};
  assign g = cmd.round[5:4];

  // Round function of both lines
  always_comb begin
    tl = rotl(al + bfun(g, bl, cl, dl) + store[sel_l(cmd.round)] + add_l(g),
              rot_l(cmd.round));
    tr = rotl(ar + bfun(2'd3 - g, br, cr, dr) + store[sel_r(cmd.round)] + add_r(g),
              rot_r(cmd.round));
  end

  // Block store, words little-endian
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store[cmd.wr_addr[5:2]][{cmd.wr_addr[1:0], 3'b000} +: 8] <= cmd.wr_data;
    end
  end

  // Byte count and captured length
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      byte_count <= '0;
    end else if (cmd.cnt_inc) begin
      byte_count <= byte_count + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_snap) begin
      bits <= {byte_count[60:0], 3'b000};
    end
  end

  // Working words
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      al <= cv[0]; bl <= cv[1]; cl <= cv[2]; dl <= cv[3];
      ar <= cv[0]; br <= cv[1]; cr <= cv[2]; dr <= cv[3];
    end else if (cmd.step) begin
      al <= dl; dl <= cl; cl <= bl; bl <= tl;
      ar <= dr; dr <= cr; cr <= br; br <= tr;
    end
  end

  // Chaining value
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      cv[0] <= IV0; cv[1] <= IV1; cv[2] <= IV2; cv[3] <= IV3;
    end else if (cmd.combine) begin
      cv[0] <= cv[1] + cl + dr;
      cv[1] <= cv[2] + dl + ar;
      cv[2] <= cv[3] + al + br;
      cv[3] <= cv[0] + bl + cr;
    end
  end

  // Length bytes go in through the write path, picked by the controller
  assign len_bits = bits;
endmodule
`default_nettype wire

// ----- rtl/rmd128_controller.sv -----
`default_nettype none
module rmd128_controller (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire rmd128_pkg::in_item_t    in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output rmd128_pkg::out_item_t        out_data,
  output rmd128_pkg::dp_cmd_t          cmd,
  input  wire rmd128_pkg::dp_status_t  status,
  input  wire logic [127:0]            chain,
  input  wire logic [63:0]             len_bits
);
  import rmd128_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0] state, state_next;
  logic [5:0] round, round_next;
  logic [5:0] pad, pad_next;     // padding write pointer
  logic       fin, fin_next;     // finishing a message
  logic       lenblk, lenblk_next; // current pad block carries length
  logic [1:0] widx, widx_next;
  logic       padding, padding_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign out_data.digest_word = chain[{widx, 5'b00000} +: 32];
  assign out_data.word_index = widx;
  assign out_data.last_word = (widx == 2'd3);

  always_comb begin
    state_next = state;
    round_next = round;
    pad_next = pad;
    fin_next = fin;
    lenblk_next = lenblk;
    widx_next = widx;
    cmd = '0;
    cmd.round = round;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.has_byte) begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = status.pos;
            cmd.wr_data = in_data.data_byte;
            cmd.cnt_inc = 1'b1;
          end
          fin_next = in_data.is_last;
          if (in_data.has_byte && status.pos == 6'd63) begin
            cmd.start = 1'b1;
            round_next = '0;
            state_next = S_RUN;
          end else if (in_data.is_last) begin
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        // count now final: capture length, write 0x80
        cmd.len_snap = 1'b1;
        cmd.wr_en = 1'b1;
        cmd.wr_addr = status.pos;
        cmd.wr_data = 8'h80;
        lenblk_next = (status.pos < LEN_POS);
        pad_next = status.pos + 6'd1;
        state_next = (status.pos == 6'd63) ? S_RUN : S_PAD;
        cmd.start = (status.pos == 6'd63);
        round_next = '0;
        fin_next = 1'b0;
      end
      S_PAD: begin
        cmd.wr_en = 1'b1;
        cmd.wr_addr = pad;
        if (lenblk && pad >= LEN_POS) begin
          cmd.wr_data = len_bits[{pad[2:0], 3'b000} +: 8];
        end else begin
          cmd.wr_data = 8'h00;
        end
        pad_next = pad + 6'd1;
        if (pad == 6'd63) begin
          cmd.start = 1'b1;
          round_next = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        round_next = round + 6'd1;
        if (round == 6'd63) begin
          state_next = S_COMB;
        end
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        if (fin) begin
          state_next = S_HOLD;
        end else if (lenblk) begin
          widx_next = '0;
          state_next = S_OUT;
        end else if (pad == 6'd0 && lenblk == 1'b0 && padding) begin
          // second pad block holds zeros and the length
          lenblk_next = 1'b1;
          pad_next = '0;
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          widx_next = widx + 2'd1;
          if (widx == 2'd3) begin
            cmd.init = 1'b1;
            lenblk_next = 1'b0;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Padding flag: set from HOLD until the digest leaves
  always_comb begin
    padding_next = padding;
    if (state == S_HOLD) padding_next = 1'b1;
    if (state == S_OUT && !out_stall && widx == 2'd3) padding_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      round <= '0;
      pad <= '0;
      fin <= 1'b0;
      lenblk <= 1'b0;
      widx <= '0;
      padding <= 1'b0;
    end else begin
      state <= state_next;
      round <= round_next;
      pad <= pad_next;
      fin <= fin_next;
      lenblk <= lenblk_next;
      widx <= widx_next;
      padding <= padding_next;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/ripemd128_hash_engine.sv -----
`default_nettype none
// RIPEMD-128 hash engine.
// Input channel (in_valid/in_stall/in_data) takes one item per transfer:
// a message byte when has_byte is set, and is_last to close the message.
// Output channel (out_valid/out_stall/out_data) carries the digest as four
// 32-bit words, word_index 0 first, last_word set on the fourth.
// A byte that fills the 64-byte store starts a compression: 64 rounds,
// then a combine step; the round logic runs one round of both lines each
// cycle. A last item places 0x80, then writes padding bytes one at a time
// up to the block end, then a compression (twice when the length field
// does not fit), then the four digest words, one per cycle while out_stall
// is low.
// in_stall is high from a block start or a last item until the work ends.
// While out_stall is high the current digest word holds; no input is taken.
// Synchronous reset restores the initial chaining value and zero count.
module ripemd128_hash_engine (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire rmd128_pkg::in_item_t   in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output rmd128_pkg::out_item_t       out_data
);
  import rmd128_pkg::*;
  `include "ripemd128_hash_engine_macros.svh"

  dp_cmd_t      cmd;
  dp_status_t   status;
  logic [127:0] chain;
  logic [63:0]  len_bits;

  rmd128_controller u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cmd(cmd), .status(status), .chain(chain), .len_bits(len_bits)
  );

  rmd128_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .chain(chain),
    .len_bits(len_bits)
  );

  `RMD_ASSERT_IMPL(a_no_take_while_out, clk, rst, out_valid, in_stall, "input taken during digest")
  `RMD_ASSERT_IMPL(a_step_not_write, clk, rst, cmd.step, !cmd.wr_en, "store written during rounds")
  `RMD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled digest word changed")
endmodule
`default_nettype wire
